FILE: rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, types and word-mask helpers for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	// MAX_FRAMES must be a power of two and a multiple of the word width
	localparam int MAX_FRAMES = 65536;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_W     = 64;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int WORDS      = MAX_FRAMES / WORD_W;
	localparam int WORD_AW    = $clog2(WORDS);
	localparam int FRAME_LOG  = $clog2(MAX_FRAMES);
	localparam int FRAME_W    = FRAME_LOG + 1;      // holds MAX_FRAMES itself
	localparam int XW         = FRAME_W - BIT_W;    // word index of a frame bound
	localparam int HI_BIT     = PAGE_SHIFT + FRAME_LOG;
	localparam int ADDR_W     = 28;
	localparam int TYPE_W     = 8;
	localparam int PCNT_W     = BIT_W + 1;

	localparam logic [FRAME_W-1:0] MAX_FR         = FRAME_W'(MAX_FRAMES);
	localparam logic [FRAME_W-1:0] RESERVED_RESET = FRAME_W'(768);
	localparam logic [TYPE_W-1:0]  REGION_USABLE  = TYPE_W'(1);
	localparam logic [WORD_AW-1:0] LAST_WORD      = WORD_AW'(WORDS - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN
	} bfa_state_t;

	typedef struct packed {
		logic init_wr;   // clearing pass: write all ones at the word pointer
		logic capture;   // latch the request fields
		logic setup;     // derive ranges and limit, reset the scan
		logic scan;      // issue one word read
		logic finish;    // load the result registers
	} bfa_cmd_t;

	typedef struct packed {
		logic ptr_last;
		logic pipe_busy;
	} bfa_sts_t;

	// bits of word w whose frame number is >= x
	function automatic logic [WORD_W-1:0] ge_mask(input logic [WORD_AW-1:0] w,
		input logic [FRAME_W-1:0] x);
		logic [XW-1:0] xw;
		logic [XW-1:0] ww;
		xw = x[FRAME_W-1:BIT_W];
		ww = {{(XW-WORD_AW){1'b0}}, w};
		if (ww < xw)
			ge_mask = '0;
		else if (ww > xw)
			ge_mask = '1;
		else
			ge_mask = {WORD_W{1'b1}} << x[BIT_W-1:0];
	endfunction

	// bits of word w whose frame number is < x
	function automatic logic [WORD_W-1:0] lt_mask(input logic [WORD_AW-1:0] w,
		input logic [FRAME_W-1:0] x);
		logic [XW-1:0] xw;
		logic [XW-1:0] ww;
		xw = x[FRAME_W-1:BIT_W];
		ww = {{(XW-WORD_AW){1'b0}}, w};
		if (ww < xw)
			lt_mask = '1;
		else if (ww > xw)
			lt_mask = '0;
		else
			lt_mask = ~({WORD_W{1'b1}} << x[BIT_W-1:0]);
	endfunction

	function automatic logic [PCNT_W-1:0] popcount(input logic [WORD_W-1:0] v);
		logic [PCNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++)
			n = n + PCNT_W'(v[i]);
		popcount = n;
	endfunction

	// index of the single set bit of a one-hot word
	function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_W; i++)
			if (v[i])
				idx = idx | BIT_W'(i);
		onehot_index = idx;
	endfunction

endpackage

FILE: rtl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: clearing pass, request capture, setup, word scan and drain.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  bfa_sts_t sts,
	output bfa_cmd_t cmd
);

	bfa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.ptr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.ptr_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

endmodule

FILE: rtl/bfa_dp.sv
// ----------------------------------------------------------------------------
// bfa_dp
// Bitmap memory, range masks, first-fit pick and used-frame counter.
// ----------------------------------------------------------------------------
module bfa_dp import bfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  bfa_cmd_t           cmd,
	output bfa_sts_t           sts,
	input  logic               func,
	input  logic [TYPE_W-1:0]  region_type,
	input  logic [63:0]        region_base,
	input  logic [63:0]        region_length,
	input  logic               last_region,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FRAME_W-1:0] cfg_data,
	output logic               done,
	output logic [ADDR_W-1:0]  frame_address,
	output logic               no_memory,
	output logic [FRAME_W-1:0] used_frames
);

	logic [WORD_W-1:0] mem_q [WORDS];

	// captured request
	logic              func_q, last_q;
	logic [TYPE_W-1:0] type_q;
	logic [63:0]       base_q, len_q;

	// per-request setup
	logic [FRAME_W-1:0] lo_q, hi_q, res_q;
	logic               alloc_q;

	// persistent state
	logic [FRAME_W-1:0] limit_q, reserved_q, acc_q;

	logic [WORD_AW-1:0] rd_ptr_q;
	logic               found_q;
	logic [ADDR_W-1:0]  addr_q;

	logic               rd_v_s1;
	logic [WORD_AW-1:0] w_s1;
	logic [WORD_W-1:0]  rd_data_s1;
	logic               pc_v_s2;
	logic [WORD_W-1:0]  pc_word_s2;

	logic               done_q, nomem_q;
	logic [ADDR_W-1:0]  faddr_q;
	logic [FRAME_W-1:0] used_q;

	// setup arithmetic
	logic [64:0]        top_sum;
	logic [FRAME_W-1:0] top_f, start_f, end_sum, end_f, res_f;
	logic               usable, start_ok;

	always_comb begin
		top_sum  = {1'b0, base_q} + {1'b0, len_q};
		if (top_sum[64] || (|top_sum[63:HI_BIT]))
			top_f = MAX_FR;
		else
			top_f = {1'b0, top_sum[HI_BIT-1:PAGE_SHIFT]};
		usable   = !func_q && (type_q == REGION_USABLE);
		start_ok = ~|base_q[63:HI_BIT];
		start_f  = {1'b0, base_q[HI_BIT-1:PAGE_SHIFT]};
		end_sum  = start_f + {1'b0, len_q[HI_BIT-1:PAGE_SHIFT]};
		if ((|len_q[63:HI_BIT]) || (end_sum > MAX_FR))
			end_f = MAX_FR;
		else
			end_f = end_sum;
		res_f    = (reserved_q > MAX_FR) ? MAX_FR : reserved_q;
	end

	// word update
	logic [WORD_W-1:0]  lim_mask, clr_mask, set_mask, free_bits, pick, new_word;
	logic               take;
	logic [BIT_W-1:0]   pick_idx;
	logic [FRAME_W+PAGE_SHIFT-1:0] pick_addr;

	always_comb begin
		lim_mask  = lt_mask(w_s1, limit_q);
		clr_mask  = ge_mask(w_s1, lo_q) & lt_mask(w_s1, hi_q);
		set_mask  = lt_mask(w_s1, res_q);
		free_bits = ~rd_data_s1 & lim_mask;
		pick      = free_bits & (~free_bits + WORD_W'(1));
		take      = alloc_q && !found_q && (|free_bits);
		pick_idx  = onehot_index(pick);
		pick_addr = {{(FRAME_W-WORD_AW-BIT_W){1'b0}}, w_s1, pick_idx} << PAGE_SHIFT;
		new_word  = (rd_data_s1 & ~clr_mask) | set_mask;
		if (take)
			new_word = new_word | pick;
	end

	// bitmap memory: one write and one read port
	always_ff @(posedge clk) begin
		if (cmd.init_wr)
			mem_q[rd_ptr_q] <= '1;
		else if (rd_v_s1)
			mem_q[w_s1] <= new_word;
		if (cmd.scan)
			rd_data_s1 <= mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			rd_v_s1    <= 1'b0;
			pc_v_s2    <= 1'b0;
			limit_q    <= '0;
			acc_q      <= '0;
			reserved_q <= RESERVED_RESET;
			found_q    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan;
			pc_v_s2 <= rd_v_s1;
			done_q  <= cmd.finish;
			if (cfg_valid)
				reserved_q <= cfg_data;
			if (cmd.init_wr || cmd.scan)
				rd_ptr_q <= (rd_ptr_q == LAST_WORD) ? '0 : rd_ptr_q + WORD_AW'(1);
			if (cmd.setup) begin
				rd_ptr_q <= '0;
				acc_q    <= '0;
				found_q  <= 1'b0;
				if (usable && (top_f > limit_q))
					limit_q <= top_f;
			end
			if (rd_v_s1 && take)
				found_q <= 1'b1;
			if (pc_v_s2)
				acc_q <= acc_q + FRAME_W'(popcount(pc_word_s2));
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			type_q <= region_type;
			base_q <= region_base;
			len_q  <= region_length;
			last_q <= last_region;
		end
		if (cmd.setup) begin
			lo_q    <= (usable && start_ok) ? start_f : '0;
			hi_q    <= (usable && start_ok) ? end_f : '0;
			res_q   <= (!func_q && last_q) ? res_f : '0;
			alloc_q <= func_q;
			addr_q  <= '0;
		end
		if (rd_v_s1) begin
			pc_word_s2 <= new_word & lim_mask;
			if (take)
				addr_q <= pick_addr[ADDR_W-1:0];
		end
		if (cmd.scan)
			w_s1 <= rd_ptr_q;
		if (cmd.finish) begin
			faddr_q <= addr_q;
			nomem_q <= alloc_q && !found_q;
			used_q  <= acc_q;
		end
	end

	assign sts.ptr_last  = (rd_ptr_q == LAST_WORD);
	assign sts.pipe_busy = rd_v_s1 | pc_v_s2;
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign frame_address = faddr_q;
	assign no_memory     = nomem_q;
	assign used_frames   = used_q;

	a_used_le_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (used_q <= limit_q))
		else $error("used count above frame limit");

	a_nomem_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && nomem_q) |-> (faddr_q == '0))
		else $error("failed alloc returned an address");

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_v_s1 && cmd.scan) |-> (w_s1 != rd_ptr_q))
		else $error("read and write of the same word in one cycle");

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_wr |-> (!rd_v_s1 && !pc_v_s2))
		else $error("scan pipeline active during clearing pass");

endmodule

FILE: rtl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit physical page frame allocator over a 64-bit-word frame bitmap.
// ----------------------------------------------------------------------------
// Scan: every request walks all WORDS words from the start edge to the done
//   strobe; one bitmap word is read, updated and written back per cycle
//   through the single-port-pair bitmap memory.
// Throughput: one request at a time; busy drops with the done strobe, so the
//   next start is taken at the edge ending it.
// Reset: a clearing pass writes all ones to the bitmap, one word a cycle, over
//   all WORDS words with busy high; limit and used count reset to zero.
// Results are strobed for one cycle; the receiver cannot stall.
module bitmap_frame_allocator import bfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [TYPE_W-1:0]  region_type,
	input  logic [63:0]        region_base,
	input  logic [63:0]        region_length,
	input  logic               last_region,
	// reserved_frames write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FRAME_W-1:0] cfg_data,
	// result
	output logic               done,
	output logic [ADDR_W-1:0]  frame_address,
	output logic               no_memory,
	output logic [FRAME_W-1:0] used_frames
);

	bfa_cmd_t cmd;   // controller -> datapath
	bfa_sts_t sts;   // datapath -> controller

	// Sequencer: clearing pass after reset, then per request
	// capture -> setup -> scan of all words -> drain -> done strobe.
	bfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath: the scan pass applies region clears, the low-frame reserve or
	// the first-fit pick to each word, and recounts used frames below the
	// limit so the count is always exact.
	bfa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.region_type   (region_type),
		.region_base   (region_base),
		.region_length (region_length),
		.last_region   (last_region),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.frame_address (frame_address),
		.no_memory     (no_memory),
		.used_frames   (used_frames)
	);

endmodule

FILE: bench/bfa_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_tb_pkg
// Request function codes shared by the allocator bench and its checker.
// ----------------------------------------------------------------------------
package bfa_tb_pkg;

	localparam logic FUNC_REGION = 1'b0;   // memory map entry
	localparam logic FUNC_ALLOC  = 1'b1;   // take one frame

endpackage

FILE: bench/frame_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_alloc_checker
// Watches requests, reserve writes and result strobes of the frame allocator,
// keeps a shadow bitmap, frame limit and reserve, and compares every result.
// ----------------------------------------------------------------------------
module frame_alloc_checker import bfa_pkg::*, bfa_tb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               func,
	input  logic [TYPE_W-1:0]  region_type,
	input  logic [63:0]        region_base,
	input  logic [63:0]        region_length,
	input  logic               last_region,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [FRAME_W-1:0] cfg_data,
	input  logic               done,
	input  logic [ADDR_W-1:0]  frame_address,
	input  logic               no_memory,
	input  logic [FRAME_W-1:0] used_frames,
	output int                 fail_count,
	output int                 outstanding
);

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic               oom;
		logic [FRAME_W-1:0] used;
	} alloc_outcome_t;

	logic [WORD_W-1:0]  shadow_map [WORDS];
	logic [FRAME_W-1:0] shadow_limit;
	logic [FRAME_W-1:0] shadow_reserve;
	alloc_outcome_t     awaited [$];

	// bits of word w below the current frame limit
	function automatic logic [WORD_W-1:0] below_limit(input int w);
		int wb;
		wb = w * WORD_W;
		if (int'(shadow_limit) >= wb + WORD_W)
			return '1;
		if (int'(shadow_limit) <= wb)
			return '0;
		return ~({WORD_W{1'b1}} << (int'(shadow_limit) - wb));
	endfunction

	// set or clear frames lo .. hi-1, clipped to the bitmap
	function automatic void mark_span(input longint unsigned lo, input longint unsigned hi,
		input logic used);
		logic [WORD_W-1:0] m;
		longint unsigned   wb;
		if (hi > MAX_FRAMES)
			hi = MAX_FRAMES;
		if (lo >= hi)
			return;
		for (int w = int'(lo >> BIT_W); w <= int'((hi - 1) >> BIT_W); w++) begin
			wb = longint'(w) * WORD_W;
			m  = '1;
			if (lo > wb)
				m = m & ({WORD_W{1'b1}} << (lo - wb));
			if (hi < wb + WORD_W)
				m = m & ~({WORD_W{1'b1}} << (hi - wb));
			if (used)
				shadow_map[w] = shadow_map[w] | m;
			else
				shadow_map[w] = shadow_map[w] & ~m;
		end
	endfunction

	// apply one request to the shadow state and return its result
	function automatic alloc_outcome_t settle_request(input logic f,
		input logic [TYPE_W-1:0] t, input logic [63:0] b, input logic [63:0] l,
		input logic lst);
		alloc_outcome_t    o;
		logic [63:0]       top;
		logic [63:0]       top_frame;
		logic [63:0]       first;
		logic [WORD_W-1:0] open;
		int                cnt;
		bit                hit;
		o   = '0;
		hit = 1'b0;
		cnt = 0;
		if (f == FUNC_REGION) begin
			if (t == REGION_USABLE) begin
				top = b + l;
				if (top < b)
					top = '1;   // wrapped past 2^64
				top_frame = top >> PAGE_SHIFT;
				if (top_frame > MAX_FRAMES)
					top_frame = MAX_FRAMES;
				if (top_frame > shadow_limit)
					shadow_limit = FRAME_W'(top_frame);
				first = b >> PAGE_SHIFT;
				if (first < MAX_FRAMES)
					mark_span(first, first + (l >> PAGE_SHIFT), 1'b0);
			end
			if (lst)
				mark_span(0, shadow_reserve, 1'b1);
		end else begin
			for (int w = 0; w < WORDS && !hit; w++) begin
				open = ~shadow_map[w] & below_limit(w);
				for (int k = 0; k < WORD_W && !hit; k++) begin
					if (open[k]) begin
						hit              = 1'b1;
						shadow_map[w][k] = 1'b1;
						o.addr           = ADDR_W'((w * WORD_W + k) << PAGE_SHIFT);
					end
				end
			end
			o.oom = !hit;
		end
		for (int w = 0; w < WORDS; w++)
			cnt += $countones(shadow_map[w] & below_limit(w));
		o.used = FRAME_W'(cnt);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_outcome_t want;
		if (!arst_n) begin
			for (int w = 0; w < WORDS; w++)
				shadow_map[w] = '1;
			shadow_limit   = '0;
			shadow_reserve = RESERVED_RESET;
			awaited.delete();
			fail_count  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				shadow_reserve = cfg_data;
			// result first: it belongs to an earlier request than one taken this edge
			if (done) begin
				if (awaited.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("%0t: result with no request pending: addr=%h oom=%0d used=%0d",
							$time, frame_address, no_memory, used_frames);
				end else begin
					want = awaited.pop_front();
					if (frame_address !== want.addr || no_memory !== want.oom ||
						used_frames !== want.used) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10)
							$display("%0t: mismatch exp addr=%h oom=%0d used=%0d, got addr=%h oom=%0d used=%0d",
								$time, want.addr, want.oom, want.used,
								frame_address, no_memory, used_frames);
					end
				end
			end
			if (start && !busy)
				awaited.push_back(settle_request(func, region_type, region_base,
					region_length, last_region));
			outstanding <= awaited.size();
		end
	end

endmodule

FILE: bench/tb_bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator
// Drives memory map entries and frame allocations into the allocator, with a
// directed opening, then random memory maps under several reserve settings
// and sender idle rates. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator import bfa_pkg::*, bfa_tb_pkg::*;;

	// cycles with no handshake at all before the run is declared hung
	localparam int QUIET_LIMIT = 20000;
	localparam int PHASE_REQS  = 112;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               start         = 1'b0;
	logic               func          = FUNC_REGION;
	logic [TYPE_W-1:0]  region_type   = '0;
	logic [63:0]        region_base   = '0;
	logic [63:0]        region_length = '0;
	logic               last_region   = 1'b0;
	logic               cfg_valid     = 1'b0;
	logic [FRAME_W-1:0] cfg_data      = '0;
	logic               busy;
	logic               cfg_ready;
	logic               done;
	logic [ADDR_W-1:0]  frame_address;
	logic               no_memory;
	logic [FRAME_W-1:0] used_frames;

	int fail_count;
	int outstanding;
	int quiet_cycles  = 0;
	int requests_sent = 0;
	int sender_idle   = 0;   // percent of ready cycles the sender sits out

	// reserve value and sender idle rate of each random phase;
	// the middle reserve is drawn at run time
	int reserve_plan [5] = '{0, 131071, 0, 65536, 768};
	int idle_plan    [5] = '{0, 78, 13, 0, 78};

	always #5 clk = ~clk;

	bitmap_frame_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.region_type   (region_type),
		.region_base   (region_base),
		.region_length (region_length),
		.last_region   (last_region),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.frame_address (frame_address),
		.no_memory     (no_memory),
		.used_frames   (used_frames)
	);

	frame_alloc_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.region_type   (region_type),
		.region_base   (region_base),
		.region_length (region_length),
		.last_region   (last_region),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.frame_address (frame_address),
		.no_memory     (no_memory),
		.used_frames   (used_frames),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	// Hang detector: any request, reserve write or result clears it.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it. Returns on
	// the accepting edge with start still high, so a back-to-back request
	// just overwrites the fields. Idle gaps only count ready cycles, so they
	// really delay the handshake instead of hiding under busy.
	task automatic issue(input logic f, input logic [TYPE_W-1:0] t,
		input logic [63:0] b, input logic [63:0] l, input logic lst);
		if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while (busy || $urandom_range(99) < sender_idle);
		end
		start         <= 1'b1;
		func          <= f;
		region_type   <= t;
		region_base   <= b;
		region_length <= l;
		last_region   <= lst;
		do
			@(posedge clk);
		while (busy);
		requests_sent++;
	endtask

	// allocation with junk in the fields the block must ignore
	task automatic alloc_one();
		issue(FUNC_ALLOC, TYPE_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
			1'($urandom));
	endtask

	initial begin
		int                phase_end;
		int                n_reg;
		int                n_alloc;
		int                pick;
		logic [31:0]       frame_no;
		logic [63:0]       rbase;
		logic [63:0]       rlen;
		logic [TYPE_W-1:0] rtype;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part, reserve at its reset value (768 frames) ----
		// alloc before any region: limit is zero, out of memory
		alloc_one();
		// four pages at zero: limit 4, frames 0..3 free
		issue(FUNC_REGION, REGION_USABLE, 64'h0, 64'h4000, 1'b0);
		// drain them, fifth one runs dry
		repeat (5) alloc_one();
		// non-usable entry marked last still re-locks the low frames
		issue(FUNC_REGION, 8'h02, 64'h0, 64'h10_0000, 1'b1);
		// unaligned base: frames 16..31 freed, limit 32 from the rounded-down top
		issue(FUNC_REGION, REGION_USABLE, 64'h1_0800, 64'h1_0000, 1'b0);
		alloc_one();
		// lower top: limit must not shrink
		issue(FUNC_REGION, REGION_USABLE, 64'h0, 64'h2000, 1'b0);
		alloc_one();
		// zero length still raises the limit
		issue(FUNC_REGION, REGION_USABLE, 64'h4_0000, 64'h0, 1'b0);
		// region starting past the bitmap: limit saturates, nothing freed
		issue(FUNC_REGION, REGION_USABLE, 64'h1_0000_0000, 64'h1000, 1'b0);
		// top wraps past 2^64 and saturates
		issue(FUNC_REGION, REGION_USABLE, 64'hFFFF_FFFF_FFFF_F000, '1, 1'b0);
		// type all ones: ignored
		issue(FUNC_REGION, 8'hFF, 64'h0, '1, 1'b0);
		// whole space freed, then the low 768 frames locked again
		issue(FUNC_REGION, REGION_USABLE, 64'h0, '1, 1'b1);
		alloc_one();
		// the topmost frame, widest address
		issue(FUNC_REGION, REGION_USABLE, 64'hFFF_F000, 64'h2000, 1'b0);
		alloc_one();
		// type zero marked last
		issue(FUNC_REGION, 8'h00, '1, '1, 1'b1);
		alloc_one();

		// ---- random memory maps, one reserve setting per phase ----
		reserve_plan[2] = $urandom_range(1, 2000);
		for (int p = 0; p < 5; p++) begin
			// let every result come back, then write the reserve with the block idle
			start <= 1'b0;
			do
				@(posedge clk);
			while (outstanding != 0);
			cfg_valid <= 1'b1;
			cfg_data  <= FRAME_W'(reserve_plan[p]);
			do
				@(posedge clk);
			while (!cfg_ready);
			cfg_valid   <= 1'b0;
			sender_idle = idle_plan[p];

			phase_end = requests_sent + PHASE_REQS;
			while (requests_sent < phase_end) begin
				if ($urandom_range(99) < 75) begin
					// well-formed map: a few entries, last one flagged, then allocs
					n_reg = $urandom_range(1, 4);
					for (int r = 0; r < n_reg; r++) begin
						pick = $urandom_range(99);
						if (pick < 85) begin
							// mostly inside the bitmap, a few just past its end
							frame_no = $urandom_range(0, 66000);
							rbase    = 64'(frame_no) << PAGE_SHIFT;
							if ($urandom_range(3) == 0)
								rbase[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
						end else
							rbase = {$urandom, $urandom};
						pick = $urandom_range(99);
						if (pick < 60)
							rlen = 64'($urandom_range(0, 64)) << PAGE_SHIFT;
						else if (pick < 85)
							rlen = 64'($urandom_range(0, 4096)) << PAGE_SHIFT;
						else if (pick < 95)
							rlen = 64'($urandom_range(0, 70000)) << PAGE_SHIFT;
						else
							rlen = {$urandom, $urandom};
						if ($urandom_range(3) == 0)
							rlen[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
						rtype = ($urandom_range(99) < 85) ? REGION_USABLE : TYPE_W'($urandom);
						issue(FUNC_REGION, rtype, rbase, rlen, r == n_reg - 1);
					end
					n_alloc = $urandom_range(1, 8);
					repeat (n_alloc) alloc_one();
				end else begin
					// noise: anything the fields allow
					rtype = $urandom_range(1) ? REGION_USABLE : TYPE_W'($urandom);
					issue(1'($urandom), rtype, {$urandom, $urandom}, {$urandom, $urandom},
						1'($urandom));
				end
			end
		end

		// ---- drain and verdict ----
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		// room for a stray extra strobe to show up
		repeat (1100) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
